// ===== rtl/vwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex weld table package
// Shared sizes, request and status codes, and the types passed between the
// sequencer, the vertex store and the compare unit.
// ----------------------------------------------------------------------------
package vwt_pkg;

    // Table sizing.
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int COORD_W = 32;
    localparam int TOL_W   = 31;
    localparam int INDEX_W = 10;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;

    // Tolerance after reset: 1e-5 in Q8.24, rounded to nearest.
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(168);

    // Request codes. The unused code behaves as find only.
    localparam logic [REQ_W-1:0] REQ_FIND_ADD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FIND_ONLY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STAT_W-1:0] ST_ADDED     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // One stored position.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vertex_t;

    // Access request from the sequencer to the vertex store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        vertex_t           wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } store_req_t;

endpackage

// ===== rtl/vwt_store.sv =====
// ----------------------------------------------------------------------------
// Vertex store
// Single-write, single-read memory of welded positions with registered read.
// Entries hold no reset value; only written entries are ever read.
// ----------------------------------------------------------------------------
module vwt_store
    import vwt_pkg::*;
(
    input  logic       clk,
    input  store_req_t req,
    output vertex_t    rdata
);

    vertex_t mem [TABLE_DEPTH];
    vertex_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/vwt_cmp.sv =====
// ----------------------------------------------------------------------------
// Vertex compare unit
// Checks one stored vertex against the request: every axis must differ by
// strictly less than the tolerance. Differences are exact at 33 bits.
// ----------------------------------------------------------------------------
module vwt_cmp
    import vwt_pkg::*;
(
    input  vertex_t          stored,
    input  vertex_t          probe,
    input  logic [TOL_W-1:0] tolerance,
    output logic             match
);

    logic signed [COORD_W:0] diff_x, diff_y, diff_z;
    logic        [COORD_W:0] abs_x, abs_y, abs_z;
    logic        [COORD_W:0] tol_ext;

    // Exact signed differences, one sign bit wider than the coordinates.
    assign diff_x = {stored.x[COORD_W-1], stored.x} - {probe.x[COORD_W-1], probe.x};
    assign diff_y = {stored.y[COORD_W-1], stored.y} - {probe.y[COORD_W-1], probe.y};
    assign diff_z = {stored.z[COORD_W-1], stored.z} - {probe.z[COORD_W-1], probe.z};

    // Magnitudes; they never exceed 2^32 - 1, so no overflow on negation.
    assign abs_x = diff_x[COORD_W] ? (COORD_W+1)'(-diff_x) : diff_x;
    assign abs_y = diff_y[COORD_W] ? (COORD_W+1)'(-diff_y) : diff_y;
    assign abs_z = diff_z[COORD_W] ? (COORD_W+1)'(-diff_z) : diff_z;

    assign tol_ext = (COORD_W+1)'(tolerance);

    // A zero tolerance never matches.
    assign match = (abs_x < tol_ext) && (abs_y < tol_ext) && (abs_z < tol_ext);

endmodule

// ===== rtl/vwt_seq.sv =====
// ----------------------------------------------------------------------------
// Vertex weld sequencer
// Walks the stored entries one per cycle through the compare unit, stops at
// the first match, and otherwise appends, reports not found or table full.
// ----------------------------------------------------------------------------
module vwt_seq
    import vwt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [REQ_W-1:0]    req_type,
    input  vertex_t             req_pos,
    input  logic                match,
    output vertex_t             probe,
    output store_req_t          store_req,
    output logic                busy,
    output logic                done,
    output logic [INDEX_W-1:0]  vertex_index,
    output logic [STAT_W-1:0]   status
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]  pidx_reg, pidx_next;
    logic               pend_reg, pend_next;
    logic [REQ_W-1:0]   req_reg, req_next;
    vertex_t            pos_reg, pos_next;
    logic               done_reg, done_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic               issue;

    // A read is issued while the walk has not reached the fill count.
    assign issue = (state_reg == S_SCAN) && (addr_reg < count_reg);

    // Next-state logic for the walk and the result beat.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        pidx_next   = addr_reg[ADDR_W-1:0];
        pend_next   = 1'b0;
        req_next    = req_reg;
        pos_next    = pos_reg;
        done_next   = 1'b0;
        index_next  = index_reg;
        status_next = status_reg;
        store_req   = '0;
        store_req.raddr = addr_reg[ADDR_W-1:0];
        store_req.waddr = count_reg[ADDR_W-1:0];
        store_req.wdata = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_CLEAR)
                    begin
                        count_next  = '0;
                        done_next   = 1'b1;
                        index_next  = '0;
                        status_next = ST_ADDED;
                    end
                    else
                    begin
                        req_next   = req_type;
                        pos_next   = req_pos;
                        addr_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                store_req.re = issue;
                pend_next    = issue;
                addr_next    = addr_reg + CNT_W'(1);
                if (pend_reg && match)
                begin
                    // First matching entry in insertion order.
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    index_next  = INDEX_W'(pidx_reg);
                    status_next = ST_FOUND;
                end
                else if (!issue)
                begin
                    // Walk finished with no match.
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    index_next = '0;
                    if (req_reg != REQ_FIND_ADD)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else if (count_reg >= CNT_W'(TABLE_DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        store_req.we = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                        index_next   = INDEX_W'(count_reg[ADDR_W-1:0]);
                        status_next  = ST_ADDED;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        pidx_reg   <= pidx_next;
        req_reg    <= req_next;
        pos_reg    <= pos_next;
        index_reg  <= index_next;
        status_reg <= status_next;
    end

    assign probe        = pos_reg;
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign vertex_index = index_reg;
    assign status       = status_reg;

endmodule

// ===== rtl/vertex_weld_table.sv =====
// ----------------------------------------------------------------------------
// Vertex weld table
// Welds 3D positions in signed Q8.24 into a table of unique vertices with a
// per-axis tolerance, by a linear search over stored entries.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Beat contents
//   -------   --------------------   ----------------------------------------
//   request   start & !busy          req_type, pos_x, pos_y, pos_z
//   result    done (one cycle)       vertex_index, status
//   config    tolerance_we           tolerance
//
// A clear is answered in the cycle right after it is taken and never raises
// busy. A search with N stored entries holds busy while it reads the entries
// up to the first match, or all N when none matches; the single read port of
// the vertex store, one entry per cycle, sets the pace of the walk.
// The result beat is shown in the first cycle with busy low, when a new
// request may already be taken. Reset empties the table; no clearing pass is
// needed. The receiver cannot stall; each result is shown for exactly one cycle.
//
module vertex_weld_table
    import vwt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [COORD_W-1:0]  pos_x,
    input  logic [COORD_W-1:0]  pos_y,
    input  logic [COORD_W-1:0]  pos_z,
    input  logic                tolerance_we,
    input  logic [TOL_W-1:0]    tolerance,
    output logic                done,
    output logic [INDEX_W-1:0]  vertex_index,
    output logic [STAT_W-1:0]   status
);

    logic [TOL_W-1:0] tolerance_reg;
    vertex_t          req_pos;
    vertex_t          probe;
    vertex_t          stored;
    store_req_t       store_req;
    logic             match;

    // Tolerance register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOL_RESET;
        end
        else if (tolerance_we)
        begin
            tolerance_reg <= tolerance;
        end
    end

    assign req_pos.x = pos_x;
    assign req_pos.y = pos_y;
    assign req_pos.z = pos_z;

    // Search sequencer.
    vwt_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .req_pos      (req_pos),
        .match        (match),
        .probe        (probe),
        .store_req    (store_req),
        .busy         (busy),
        .done         (done),
        .vertex_index (vertex_index),
        .status       (status)
    );

    // Vertex memory.
    vwt_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (stored)
    );

    // Shared compare unit.
    vwt_cmp u_cmp (
        .stored    (stored),
        .probe     (probe),
        .tolerance (tolerance_reg),
        .match     (match)
    );

endmodule

// ===== rtl/vwt_checker.sv =====
// ----------------------------------------------------------------------------
// Vertex weld table checker
// Port-level assertions on request and result beats, bound to the top level.
// ----------------------------------------------------------------------------
module vwt_checker
    import vwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [REQ_W-1:0]   req_type,
    input  logic               done,
    input  logic [INDEX_W-1:0] vertex_index,
    input  logic [STAT_W-1:0]  status
);

    // A result beat is only given once the search has ended.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // No result beat without an accepted request just before.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !done)
        else $error("result beat without a request");

    // An accepted request either keeps the block busy or answers at once.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request vanished");

    // A clear answers the next cycle with index zero and the added code.
    a_clear_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_CLEAR) |=>
            (done && vertex_index == '0 && status == ST_ADDED))
        else $error("clear answered wrongly");

    // Not-found and full answers carry index zero.
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_NOT_FOUND || status == ST_FULL)) |->
            (vertex_index == '0))
        else $error("miss with non-zero index");

endmodule

bind vertex_weld_table vwt_checker u_vwt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .done         (done),
    .vertex_index (vertex_index),
    .status       (status)
);

// ===== bench/weld_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex weld table checker package
// Holds a shadow copy of the weld table and its tolerance. It works out the
// answer that each accepted request must produce and checks the answers that
// come back, in order.
// ----------------------------------------------------------------------------
package weld_tb_pkg;
    import vwt_pkg::*;

    // Codes and extremes that the bench uses by name.
    localparam logic [REQ_W-1:0]   REQ_RESERVED = 2'd3;
    localparam logic [COORD_W-1:0] COORD_MIN    = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] COORD_MAX    = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [TOL_W-1:0]   TOL_MAX      = {TOL_W{1'b1}};

    // One answer beat as the block shows it.
    typedef struct packed {
        logic [INDEX_W-1:0] vidx;
        logic [STAT_W-1:0]  stat;
    } weld_answer_t;

    class weld_table_shadow;
        logic signed [COORD_W-1:0] kept_x [TABLE_DEPTH];
        logic signed [COORD_W-1:0] kept_y [TABLE_DEPTH];
        logic signed [COORD_W-1:0] kept_z [TABLE_DEPTH];
        int unsigned               n_kept;
        logic [TOL_W-1:0]          weld_tol;
        weld_answer_t              awaited[$];
        int unsigned               mismatches;

        function new();
            n_kept     = 0;
            weld_tol   = TOL_RESET;
            mismatches = 0;
        endfunction

        function void set_tolerance(logic [TOL_W-1:0] t);
            weld_tol = t;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // The distance is taken at full width, so coordinates of opposite sign
        // far apart can never look close through a wrap.
        function bit is_close(logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b);
            longint delta;
            delta = longint'(a) - longint'(b);
            if (delta < 0)
                delta = -delta;
            return delta < longint'(weld_tol);
        endfunction

        // Works out the answer to an accepted request and updates the table.
        function void note_request(logic [REQ_W-1:0] req, logic [COORD_W-1:0] x,
                                   logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
            weld_answer_t ans;
            int unsigned  i;
            bit           hit;
            ans.vidx = '0;
            ans.stat = ST_NOT_FOUND;
            hit      = 1'b0;
            if (req == REQ_CLEAR)
            begin
                n_kept   = 0;
                ans.stat = ST_ADDED;
            end
            else
            begin
                // First match in insertion order wins.
                i = 0;
                while (i < n_kept && !hit)
                begin
                    if (is_close(kept_x[i], x) && is_close(kept_y[i], y) &&
                        is_close(kept_z[i], z))
                        hit = 1'b1;
                    else
                        i++;
                end
                if (hit)
                begin
                    ans.vidx = INDEX_W'(i);
                    ans.stat = ST_FOUND;
                end
                else if (req != REQ_FIND_ADD)
                    ans.stat = ST_NOT_FOUND;
                else if (n_kept >= TABLE_DEPTH)
                    ans.stat = ST_FULL;
                else
                begin
                    kept_x[n_kept] = x;
                    kept_y[n_kept] = y;
                    kept_z[n_kept] = z;
                    ans.vidx       = INDEX_W'(n_kept);
                    ans.stat       = ST_ADDED;
                    n_kept++;
                end
            end
            awaited.push_back(ans);
        endfunction

        // Compares an answer beat with the oldest outstanding answer.
        function void check_result(logic [INDEX_W-1:0] vidx, logic [STAT_W-1:0] stat);
            weld_answer_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("answer with no request outstanding: index %0d status %0d",
                             vidx, stat);
            end
            else
            begin
                want = awaited.pop_front();
                if (want.vidx !== vidx || want.stat !== stat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("wrong answer: want index %0d status %0d, got index %0d status %0d",
                                 want.vidx, want.stat, vidx, stat);
                end
            end
        endfunction
    endclass

endpackage

// ===== bench/vertex_weld_table_tb.sv =====
// ----------------------------------------------------------------------------
// Vertex weld table testbench
// Drives weld requests through the start/busy handshake with random gaps and
// checks every answer beat against a shadow table. A directed run covers
// tolerance boundaries, coordinate extremes and every request type; random
// phases follow at several tolerances.
// ----------------------------------------------------------------------------
module vertex_weld_table_tb import vwt_pkg::*, weld_tb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [REQ_W-1:0]   req_type;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic               tolerance_we;
    logic [TOL_W-1:0]   tolerance;
    logic               done;
    logic [INDEX_W-1:0] vertex_index;
    logic [STAT_W-1:0]  status;

    weld_table_shadow shadow = new();

    vertex_weld_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .tolerance_we (tolerance_we),
        .tolerance    (tolerance),
        .done         (done),
        .vertex_index (vertex_index),
        .status       (status)
    );

    // Free-running clock, 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #15_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Every answer beat is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_result(vertex_index, status);
    end

    // Mostly short gaps, now and then a long one.
    function automatic int rand_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A coordinate from the extremes, from the whole range or from near zero.
    function automatic logic [COORD_W-1:0] rand_coord();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return COORD_MIN;
                1:       return COORD_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        else if (roll < 6)
            return $urandom;
        return COORD_W'(int'($urandom_range(0, 2000)) - 1000);
    endfunction

    // Moves a stored coordinate to just inside, on, or just past the
    // tolerance, or somewhere within it; the sum wraps at the edges.
    function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] base,
                                                 logic [TOL_W-1:0] tol);
        longint span;
        longint off;
        span = longint'(tol);
        case ($urandom_range(0, 5))
            0:       off = 0;
            1:       off = span - 1;
            2:       off = span;
            3:       off = span + 1;
            default: off = (span == 0) ? 0 : longint'($urandom) % span;
        endcase
        if ($urandom_range(0, 1))
            off = -off;
        return COORD_W'(longint'($signed(base)) + off);
    endfunction

    // Presents one request beat after the given gap and holds it until the
    // block takes it. Returns at the falling edge after the beat.
    task automatic issue(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] x,
                         input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                         input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        req_type <= req;
        pos_x    <= x;
        pos_y    <= y;
        pos_z    <= z;
        do
            @(posedge clk);
        while (busy);
        shadow.note_request(req, x, y, z);
        @(negedge clk);
    endtask

    // Holds off new requests until every answer is back.
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (shadow.pending() != 0)
            @(negedge clk);
    endtask

    // Tolerance is only changed while the block has nothing in hand.
    task automatic write_tolerance(input logic [TOL_W-1:0] t);
        wait_drained();
        repeat (2) @(negedge clk);
        tolerance_we <= 1'b1;
        tolerance    <= t;
        shadow.set_tolerance(t);
        @(negedge clk);
        tolerance_we <= 1'b0;
    endtask

    // One random request: mostly near copies of stored vertices, with some
    // fresh positions, clears and noise on the request type.
    task automatic random_item(input bit quiet);
        logic [REQ_W-1:0]   req;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        int                 roll;
        int                 pick;
        x    = rand_coord();
        y    = rand_coord();
        z    = rand_coord();
        roll = $urandom_range(0, 99);
        if (roll < 4)
            req = REQ_CLEAR;
        else if (roll < 12)
            req = REQ_W'($urandom_range(0, 3));
        else
        begin
            pick = $urandom_range(0, 19);
            req  = (pick < 15) ? REQ_FIND_ADD : (pick < 19) ? REQ_FIND_ONLY : REQ_RESERVED;
            if (shadow.n_kept != 0 && $urandom_range(0, 9) < 6)
            begin
                pick = $urandom_range(0, shadow.n_kept - 1);
                x    = nudge(shadow.kept_x[pick], shadow.weld_tol);
                y    = nudge(shadow.kept_y[pick], shadow.weld_tol);
                z    = nudge(shadow.kept_z[pick], shadow.weld_tol);
            end
        end
        issue(req, x, y, z, quiet ? 0 : rand_gap());
    endtask

    initial
    begin
        logic [TOL_W-1:0] phase_tol [8];
        bit               quiet;
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_FIND_ADD;
        pos_x        = '0;
        pos_y        = '0;
        pos_z        = '0;
        tolerance_we = 1'b0;
        tolerance    = TOL_RESET;
        quiet        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: boundaries of the reset tolerance and the coordinate range.
        issue(REQ_FIND_ONLY, '0, '0, '0, rand_gap());
        issue(REQ_FIND_ADD, '0, '0, '0, rand_gap());
        issue(REQ_FIND_ADD, COORD_W'(167), COORD_W'(-167), '0, rand_gap());
        issue(REQ_FIND_ADD, COORD_W'(168), '0, '0, rand_gap());
        issue(REQ_FIND_ADD, '0, '0, COORD_W'(-168), rand_gap());
        issue(REQ_FIND_ADD, COORD_MIN, COORD_MIN, COORD_MIN, rand_gap());
        issue(REQ_FIND_ADD, COORD_MAX, COORD_MAX, COORD_MAX, rand_gap());
        issue(REQ_FIND_ONLY, COORD_MAX, COORD_MAX - 167, COORD_MAX, rand_gap());
        issue(REQ_RESERVED, COORD_W'(1), '0, '0, rand_gap());
        issue(REQ_RESERVED, COORD_W'(5000), '0, '0, rand_gap());
        issue(REQ_FIND_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, rand_gap());
        issue(REQ_FIND_ADD, 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, rand_gap());
        issue(REQ_CLEAR, '1, '1, '1, rand_gap());
        issue(REQ_FIND_ONLY, '0, '0, '0, rand_gap());
        issue(REQ_FIND_ADD, '0, '0, '0, rand_gap());

        // Widest tolerance: opposite extremes must not meet through a wrap.
        write_tolerance(TOL_MAX);
        issue(REQ_FIND_ADD, COORD_MIN, COORD_MIN, COORD_MIN, rand_gap());
        issue(REQ_FIND_ADD, COORD_MAX, COORD_MAX, COORD_MAX, rand_gap());
        issue(REQ_FIND_ONLY, '1, '1, '1, rand_gap());
        issue(REQ_CLEAR, '0, '0, '0, rand_gap());
        issue(REQ_FIND_ADD, COORD_MIN, COORD_MIN, COORD_MIN, rand_gap());
        issue(REQ_FIND_ONLY, '1, '1, '1, rand_gap());
        issue(REQ_FIND_ONLY, COORD_W'(-2), COORD_W'(-2), COORD_W'(-2), rand_gap());

        // Zero tolerance never matches; a tolerance of one matches exact copies.
        write_tolerance('0);
        issue(REQ_FIND_ADD, COORD_W'(5), COORD_W'(5), COORD_W'(5), rand_gap());
        issue(REQ_FIND_ADD, COORD_W'(5), COORD_W'(5), COORD_W'(5), rand_gap());
        write_tolerance(TOL_W'(1));
        issue(REQ_FIND_ADD, COORD_W'(5), COORD_W'(5), COORD_W'(5), rand_gap());

        // Random phases, each at its own tolerance.
        phase_tol[0] = TOL_RESET;
        phase_tol[1] = TOL_W'(1);
        phase_tol[2] = '0;
        phase_tol[3] = TOL_MAX;
        phase_tol[4] = TOL_W'($urandom);
        phase_tol[5] = TOL_W'(1 << $urandom_range(4, 20)) + TOL_W'($urandom_range(0, 15));
        phase_tol[6] = TOL_W'($urandom_range(2, 4096));
        phase_tol[7] = TOL_W'($urandom);
        for (int p = 0; p < 8; p++)
        begin
            write_tolerance(phase_tol[p]);
            for (int n = 0; n < 69; n++)
            begin
                // Stretches with and without idling.
                if (n % 24 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                random_item(quiet);
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
            end
        end

        // Empty the table once more before finishing.
        issue(REQ_CLEAR, '0, '0, '0, rand_gap());

        // Let the last answers land, then watch for strays.
        wait_drained();
        repeat (TABLE_DEPTH + 8) @(negedge clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== vertex_weld_table.f =====
rtl/vwt_pkg.sv
rtl/vwt_store.sv
rtl/vwt_cmp.sv
rtl/vwt_seq.sv
rtl/vertex_weld_table.sv
rtl/vwt_checker.sv
bench/weld_tb_pkg.sv
bench/vertex_weld_table_tb.sv
